@@ rtl/four_voice_sample_mixer_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the four-voice sample mixer core
// ---------------------------------------------------------------------------
`ifndef FOUR_VOICE_SAMPLE_MIXER_CORE_DEFINES_SVH
`define FOUR_VOICE_SAMPLE_MIXER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FVSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("four_voice_sample_mixer_core: check failed");

// Next-cycle implication, disabled in reset.
`define FVSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("four_voice_sample_mixer_core: check failed");

`endif

@@ rtl/fvsm_pkg.sv @@
// ---------------------------------------------------------------------------
// fvsm_pkg
// Types, sizes and codes shared by the sample mixer core.
// ---------------------------------------------------------------------------
`default_nettype none

package fvsm_pkg;

   // voice slots: a power of two
   localparam int VOICES_LOG2 = 2;
   localparam int VOICES      = 1 << VOICES_LOG2;
   localparam int VIDX_W      = (VOICES_LOG2 > 0) ? VOICES_LOG2 : 1;

   // sample store: a power of two
   localparam int STORE_AW    = 16;
   localparam int STORE_DEPTH = 1 << STORE_AW;

   // field widths
   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 16;
   localparam int SAMPLE_W = 8;
   localparam int LEN_W    = 17;
   localparam int VOL_W    = 9;
   localparam int OUT_W    = 8;
   localparam int MASK_W   = 4;

   // start + position, wide enough not to lose the carry
   localparam int PTR_W = (STORE_AW > LEN_W + 1) ? STORE_AW : LEN_W + 1;

   // mix arithmetic
   localparam int SUM_W    = SAMPLE_W + VOICES_LOG2;
   localparam int PROD_W   = SUM_W + VOL_W + 1;
   localparam int GAIN     = 120;
   localparam int GAIN_W   = 7;
   localparam int SCALED_W = PROD_W + GAIN_W;
   // divisor 128 * VOICES * 256
   localparam int SHIFT    = 7 + 8 + VOICES_LOG2;

   localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(256);
   localparam logic signed [SCALED_W-1:0] ROUND_BIAS =
      SCALED_W'((64'd1 << SHIFT) - 64'd1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PLAY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]           command;
      logic [ADDR_W-1:0]          address;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [LEN_W-1:0]           clip_length;
   } fvsm_req_type;

   typedef struct packed {
      logic [OUT_W-1:0]  sample_out;
      logic [MASK_W-1:0] active_mask;
   } fvsm_rsp_type;

   typedef struct packed {
      logic              store_write;
      logic              req_latch;
      logic              sum_clear;
      logic              scan_step;
      logic              play_commit;
      logic              tick_read;
      logic              scale_mul;
      logic              scale_gain;
      logic              rsp_load;
      logic [VIDX_W-1:0] voice_idx;
   } fvsm_cmd_type;

   typedef struct packed {
      logic req_write;
      logic req_play;
      logic req_tick;
      logic rsp_blocked;
   } fvsm_status_type;

endpackage

`default_nettype wire

@@ rtl/fvsm_ram.sv @@
// ---------------------------------------------------------------------------
// fvsm_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fvsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/fvsm_ctrl.sv @@
// ---------------------------------------------------------------------------
// fvsm_ctrl
// Sequencer: takes a beat, walks the voice slots and steps the mix scaling.
// ---------------------------------------------------------------------------
`default_nettype none

module fvsm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  fvsm_pkg::fvsm_status_type status,
   output fvsm_pkg::fvsm_cmd_type    cmd
);

   import fvsm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAY_SCAN,
      ST_PLAY_COMMIT,
      ST_TICK_READ,
      ST_TICK_DRAIN,
      ST_SCALE_MUL,
      ST_SCALE_GAIN,
      ST_ROUND
   } state_type;

   localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);

   state_type         state_ff, state_in;
   logic              stall_ff;
   logic [VIDX_W-1:0] idx_ff, idx_in;
   logic              accept;

   assign accept = req_valid & ~stall_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.voice_idx = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.req_write) begin
                  cmd.store_write = 1'b1;
               end else if (status.req_play) begin
                  cmd.req_latch = 1'b1;
                  idx_in        = '0;
                  state_in      = ST_PLAY_SCAN;
               end else if (status.req_tick) begin
                  cmd.sum_clear = 1'b1;
                  idx_in        = '0;
                  state_in      = ST_TICK_READ;
               end
            end
         end
         ST_PLAY_SCAN: begin
            cmd.scan_step = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_PLAY_COMMIT;
            end else begin
               idx_in = idx_ff + VIDX_W'(1);
            end
         end
         ST_PLAY_COMMIT: begin
            cmd.play_commit = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_TICK_READ: begin
            cmd.tick_read = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_TICK_DRAIN;
            end else begin
               idx_in = idx_ff + VIDX_W'(1);
            end
         end
         ST_TICK_DRAIN: begin
            state_in = ST_SCALE_MUL;
         end
         ST_SCALE_MUL: begin
            cmd.scale_mul = 1'b1;
            state_in      = ST_SCALE_GAIN;
         end
         ST_SCALE_GAIN: begin
            cmd.scale_gain = 1'b1;
            state_in       = ST_ROUND;
         end
         ST_ROUND: begin
            if (!status.rsp_blocked) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
         idx_ff   <= idx_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

`default_nettype wire

@@ rtl/fvsm_datapath.sv @@
// ---------------------------------------------------------------------------
// fvsm_datapath
// Voice slot registers, sample store, mix accumulator, scaler and result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module fvsm_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  fvsm_pkg::fvsm_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fvsm_pkg::fvsm_rsp_type           rsp_data,
   input  logic                             csr_write_enable,
   input  logic [fvsm_pkg::VOL_W-1:0]       csr_write_data,
   input  fvsm_pkg::fvsm_cmd_type           cmd,
   output fvsm_pkg::fvsm_status_type        status
);

   import fvsm_pkg::*;

   // control state
   logic [VOL_W-1:0]  master_ff, master_in;
   logic [VOICES-1:0] busy_ff, busy_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [ADDR_W-1:0] start_ff [VOICES];
   logic [ADDR_W-1:0] start_in [VOICES];
   logic [LEN_W-1:0]  len_ff   [VOICES];
   logic [LEN_W-1:0]  len_in   [VOICES];
   logic [LEN_W-1:0]  pos_ff   [VOICES];
   logic [LEN_W-1:0]  pos_in   [VOICES];
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  req_len_ff, req_len_in;
   logic              found_ff, found_in;
   logic [VIDX_W-1:0] sel_idx_ff, sel_idx_in;
   logic [LEN_W-1:0]  sel_pos_ff, sel_pos_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SCALED_W-1:0] scaled_ff, scaled_in;
   fvsm_rsp_type               rsp_ff, rsp_in;

   // slot under the sequencer's index
   logic              cur_busy;
   logic [LEN_W-1:0]  cur_pos, cur_len, pos_next;
   logic [PTR_W-1:0]  rd_ptr, wr_ptr;
   logic [SAMPLE_W-1:0]        rd_data;
   logic signed [SCALED_W-1:0] biased;
   logic [VOICES+MASK_W-1:0]   busy_ext;

   assign cur_busy = busy_ff[cmd.voice_idx];
   assign cur_pos  = pos_ff[cmd.voice_idx];
   assign cur_len  = len_ff[cmd.voice_idx];
   assign pos_next = cur_pos + LEN_W'(1);

   // store addresses wrap at the store depth
   assign wr_ptr = PTR_W'(req_data.address);
   assign rd_ptr = PTR_W'(start_ff[cmd.voice_idx]) + PTR_W'(cur_pos);

   fvsm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_write),
      .wr_addr (wr_ptr[STORE_AW-1:0]),
      .wr_data (req_data.sample_value),
      .rd_en   (cmd.tick_read),
      .rd_addr (rd_ptr[STORE_AW-1:0]),
      .rd_data (rd_data)
   );

   // request decode for the sequencer
   always_comb begin
      status = '0;
      status.rsp_blocked = rsp_valid_ff & rsp_stall;
      unique case (req_data.command)
         CMD_WRITE: status.req_write = 1'b1;
         CMD_PLAY:  status.req_play  = (req_data.clip_length != '0);
         CMD_TICK:  status.req_tick  = 1'b1;
         default:   status.req_write = 1'b0;
      endcase
   end

   always_comb begin
      master_in  = csr_write_enable ? csr_write_data : master_ff;
      busy_in    = busy_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      addr_in    = addr_ff;
      req_len_in = req_len_ff;
      found_in   = found_ff;
      sel_idx_in = sel_idx_ff;
      sel_pos_in = sel_pos_ff;

      if (cmd.req_latch) begin
         addr_in    = req_data.address;
         req_len_in = req_data.clip_length;
      end

      // slot search: first free slot, else furthest played, lowest index on ties
      if (cmd.scan_step) begin
         if (cmd.voice_idx == '0) begin
            found_in   = ~cur_busy;
            sel_idx_in = cmd.voice_idx;
            sel_pos_in = cur_pos;
         end else if (!found_ff) begin
            if (!cur_busy) begin
               found_in   = 1'b1;
               sel_idx_in = cmd.voice_idx;
            end else if (cur_pos > sel_pos_ff) begin
               sel_idx_in = cmd.voice_idx;
               sel_pos_in = cur_pos;
            end
         end
      end

      if (cmd.play_commit) begin
         busy_in[sel_idx_ff]  = 1'b1;
         start_in[sel_idx_ff] = addr_ff;
         len_in[sel_idx_ff]   = req_len_ff;
         pos_in[sel_idx_ff]   = '0;
      end

      if (cmd.tick_read && cur_busy) begin
         pos_in[cmd.voice_idx] = pos_next;
         if (pos_next >= cur_len) begin
            busy_in[cmd.voice_idx] = 1'b0;
         end
      end
   end

   // read data lands in the cycle after the read
   assign pend_in = cmd.tick_read & cur_busy;

   always_comb begin
      sum_in = sum_ff;
      if (cmd.sum_clear) begin
         sum_in = '0;
      end else if (pend_ff) begin
         sum_in = sum_ff + SUM_W'($signed(rd_data));
      end
   end

   assign prod_in = cmd.scale_mul
      ? PROD_W'(sum_ff) * PROD_W'($signed({1'b0, master_ff}))
      : prod_ff;

   assign scaled_in = cmd.scale_gain
      ? SCALED_W'(prod_ff) * $signed(SCALED_W'(GAIN))
      : scaled_ff;

   // truncate toward zero: bias negatives before the shift
   assign biased   = scaled_ff + (scaled_ff[SCALED_W-1] ? ROUND_BIAS : SCALED_W'(0));
   assign busy_ext = {MASK_W'(0), busy_ff};

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.sample_out  = biased[SHIFT +: OUT_W];
         rsp_in.active_mask = busy_ext[MASK_W-1:0];
      end
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= VOL_RESET;
         busy_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         master_ff    <= master_in;
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      len_ff     <= len_in;
      pos_ff     <= pos_in;
      addr_ff    <= addr_in;
      req_len_ff <= req_len_in;
      found_ff   <= found_in;
      sel_idx_ff <= sel_idx_in;
      sel_pos_ff <= sel_pos_in;
      sum_ff     <= sum_in;
      prod_ff    <= prod_in;
      scaled_ff  <= scaled_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/four_voice_sample_mixer_core.sv @@
// ---------------------------------------------------------------------------
// four_voice_sample_mixer_core
// Four-slot mixer of signed 8-bit clips held in a 64K-sample store.
// ---------------------------------------------------------------------------
//
//   port group   direction   beat carries
//   req_         in          command, address, sample_value, clip_length
//   rsp_         out         sample_out, active_mask (one per tick)
//   csr_         in          master gain, 9 bits, no read-back
//
// Sequence: a write beat goes straight to the store; a play compares one
// slot per cycle, then commits; a tick reads one slot per cycle, set by
// the single store read port, then takes a drain step for the registered
// read and three scaling steps.
// Reset: synchronous, active high; all slots free, master gain 256. The
// store itself is not cleared.
// A result waits in the output register while rsp_stall is high; write and
// play beats are still taken meanwhile, a tick holds in its last step.
// ---------------------------------------------------------------------------
`default_nettype none

module four_voice_sample_mixer_core (
   input  logic                       clock,
   input  logic                       reset,
   // request beats
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fvsm_pkg::fvsm_req_type     req_data,
   // result beats
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fvsm_pkg::fvsm_rsp_type     rsp_data,
   // master gain
   input  logic                       csr_write_enable,
   input  logic [fvsm_pkg::VOL_W-1:0] csr_write_data
);

   import fvsm_pkg::*;

   // sequencer to datapath
   fvsm_cmd_type    cmd;
   // datapath to sequencer: request decode, output register full
   fvsm_status_type status;

   // Sequencer: idle accepts a beat; play walks the slots to pick one,
   // tick walks them reading the store and then steps the scaler.
   fvsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: slot registers, store, accumulator, gain and truncation,
   // and the result register that parts the output side.
   fvsm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

@@ rtl/four_voice_sample_mixer_core_checker.sv @@
// ---------------------------------------------------------------------------
// four_voice_sample_mixer_core_checker
// Port-level checks on the mixer core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "four_voice_sample_mixer_core_defines.svh"

module four_voice_sample_mixer_core_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input fvsm_pkg::fvsm_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input fvsm_pkg::fvsm_rsp_type rsp_data
);

   import fvsm_pkg::*;

   logic tick_beat;
   logic write_beat;

   assign tick_beat  = req_valid & ~req_stall & (req_data.command == CMD_TICK);
   assign write_beat = req_valid & ~req_stall & (req_data.command == CMD_WRITE);

   // a tick keeps the request side busy while the slots are read
   `FVSM_ASSERT_NEXT(a_tick_busy, clock, reset, tick_beat, req_stall)
   // a store write does not stall the request side after it
   `FVSM_ASSERT_NEXT(a_write_quick, clock, reset, write_beat, !req_stall)
   // results only come out of a tick in progress
   `FVSM_ASSERT_IMPLY(a_rsp_from_tick, clock, reset, $rose(rsp_valid), $past(req_stall))
   // a stalled result holds
   `FVSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_data))

endmodule

bind four_voice_sample_mixer_core four_voice_sample_mixer_core_checker u_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// Testbench for four_voice_sample_mixer_core
// Drives write, play and tick beats with random gaps and result back-pressure.
// A scoreboard keeps its own copy of the slots, the sample store and the
// master gain, predicts each tick's mixed byte and slot mask, and compares
// every result beat field by field in order.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fvsm_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam longint MIX_GAIN    = 120;
   localparam longint MIX_DIVISOR = 128 * VOICES * 256;
   localparam int     SETTLE      = 16;   // longer than a play or tick takes
   localparam int     PHASE_BEATS = 75;

   // -----------------------------------------------------------------------
   // Scoreboard: slot state, store image, gain and the queue of mixes due
   // -----------------------------------------------------------------------
   class mix_scoreboard;
      logic [VOL_W-1:0]  out_gain;
      bit                busy [VOICES];
      logic [ADDR_W-1:0] clip_start [VOICES];
      logic [LEN_W-1:0]  clip_len [VOICES];
      logic [LEN_W-1:0]  played [VOICES];
      logic [7:0]        store_mem [STORE_DEPTH];
      bit                written [STORE_DEPTH];
      fvsm_rsp_type      expected_mix [$];
      int                errors;

      function new();
         out_gain = VOL_RESET;
         errors = 0;
         for (int v = 0; v < VOICES; v++) begin
            busy[v] = 1'b0;
            clip_start[v] = '0;
            clip_len[v] = '0;
            played[v] = '0;
         end
      endfunction

      // store address the slot reads on its next tick; wraps round the store
      function logic [ADDR_W-1:0] next_read(int v);
         next_read = clip_start[v] + played[v][ADDR_W-1:0];
      endfunction

      function void start_clip(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
         int slot;
         int most;
         slot = -1;
         most = 0;
         if (len == 0) return;   // zero length: nothing changes
         for (int v = 0; v < VOICES; v++) begin
            if (!busy[v]) begin
               slot = v;
               break;
            end
            // strictly greater, so the lowest index keeps a tie
            if (played[v] > played[most]) most = v;
         end
         if (slot < 0) slot = most;
         busy[slot] = 1'b1;
         clip_start[slot] = addr;
         clip_len[slot] = len;
         played[slot] = '0;
      endfunction

      function fvsm_rsp_type mix_tick();
         int                    total;
         longint                scaled;
         logic signed [7:0]     smp;
         logic [ADDR_W-1:0]     where;
         fvsm_rsp_type          mix;
         total = 0;
         for (int v = 0; v < VOICES; v++) begin
            if (busy[v]) begin
               where = next_read(v);
               smp = store_mem[where];
               total += smp;
               played[v] = played[v] + 1'b1;
               if (played[v] >= clip_len[v]) busy[v] = 1'b0;
            end
         end
         // integer division truncates toward zero, as wanted
         scaled = (longint'(total) * MIX_GAIN * longint'(out_gain)) / MIX_DIVISOR;
         mix.sample_out = scaled[7:0];
         for (int v = 0; v < MASK_W; v++)
            mix.active_mask[v] = (v < VOICES) ? busy[v] : 1'b0;
         return mix;
      endfunction

      function void note_beat(fvsm_req_type beat);
         case (beat.command)
            CMD_WRITE: begin
               store_mem[beat.address] = beat.sample_value;
               written[beat.address] = 1'b1;
            end
            CMD_PLAY: start_clip(beat.address, beat.clip_length);
            CMD_TICK: expected_mix.push_back(mix_tick());
            default: ;   // unused code: ignored
         endcase
      endfunction

      function void check_mix(fvsm_rsp_type got);
         fvsm_rsp_type want;
         if (expected_mix.size() == 0) begin
            $error("result beat with none expected: sample_out 0x%02h active_mask %b",
                   got.sample_out, got.active_mask);
            errors++;
            return;
         end
         want = expected_mix.pop_front();
         if (got.sample_out !== want.sample_out) begin
            $error("sample_out: expected 0x%02h, actual 0x%02h",
                   want.sample_out, got.sample_out);
            errors++;
         end
         if (got.active_mask !== want.active_mask) begin
            $error("active_mask: expected %b, actual %b",
                   want.active_mask, got.active_mask);
            errors++;
         end
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // Clock, DUT and stimulus signals
   // -----------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   fvsm_req_type     req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   fvsm_rsp_type     rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [VOL_W-1:0] csr_write_data = '0;

   mix_scoreboard mix;
   bit idle_on = 1'b1;
   int stall_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   four_voice_sample_mixer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // receiver back-pressure in bursts of random length
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall = 1'b1;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // result beats are taken at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) mix.check_mix(rsp_data);
   end

   // -----------------------------------------------------------------------
   // Beat construction and driving
   // -----------------------------------------------------------------------
   function automatic fvsm_req_type make_beat(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                              logic [SAMPLE_W-1:0] smp, logic [LEN_W-1:0] len);
      fvsm_req_type beat;
      beat.command = cmd;
      beat.address = addr;
      beat.sample_value = smp;
      beat.clip_length = len;
      return beat;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return 8'h7F;
         1: return 8'h80;
         2: return 8'hFF;
         default: return SAMPLE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic fvsm_req_type random_beat();
      fvsm_req_type beat;
      int           pick;
      int           v;
      beat = make_beat(CMD_TICK, ADDR_W'($urandom_range(0, 65535)),
                       SAMPLE_W'($urandom_range(0, 255)),
                       LEN_W'($urandom_range(0, 65536)));
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         beat.command = CMD_UNUSED;
      end else if (pick < 38) begin
         beat.command = CMD_WRITE;
         beat.sample_value = pick_sample();
         // on a coin toss, a write lands just ahead of a randomly picked slot if it is playing
         v = $urandom_range(0, VOICES - 1);
         if ($urandom_range(0, 1) == 0 && mix.busy[v])
            beat.address = mix.next_read(v) + ADDR_W'($urandom_range(0, 7));
      end else if (pick < 55) begin
         beat.command = CMD_PLAY;
         case ($urandom_range(0, 29))
            0:       beat.clip_length = '0;
            1:       beat.clip_length = LEN_W'(65536);
            2, 3, 4: beat.clip_length = LEN_W'($urandom_range(100, 2000));
            default: beat.clip_length = LEN_W'($urandom_range(1, 40));
         endcase
         // start near the top now and then so the clip wraps round the store
         if ($urandom_range(0, 9) == 0)
            beat.address = ADDR_W'(16'hFFFF - $urandom_range(0, 15));
      end
      return beat;
   endfunction

   // one beat across the request handshake, with an optional gap before it
   task automatic send_beat(input fvsm_req_type beat);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = beat;
      do @(posedge clock); while (req_stall);
      mix.note_beat(beat);
   endtask

   // a tick never reads a store entry that was never written: fill it first
   task automatic send_item(input fvsm_req_type beat);
      logic [ADDR_W-1:0] where;
      if (beat.command == CMD_TICK) begin
         for (int v = 0; v < VOICES; v++) begin
            where = mix.next_read(v);
            if (mix.busy[v] && !mix.written[where])
               send_beat(make_beat(CMD_WRITE, where, pick_sample(),
                                   LEN_W'($urandom_range(0, 65536))));
         end
      end
      send_beat(beat);
   endtask

   // gain is changed only with the core idle
   task automatic set_out_gain(input logic [VOL_W-1:0] vol);
      @(negedge clock);
      req_valid = 1'b0;
      while (mix.expected_mix.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = vol;
      @(negedge clock);
      csr_write_enable = 1'b0;
      mix.out_gain = vol;
   endtask

   task automatic run_directed();
      // wrap across the top of the store, sign extremes
      send_item(make_beat(CMD_WRITE, 16'hFFFF, 8'h80, '0));
      send_item(make_beat(CMD_WRITE, 16'h0000, 8'h7F, '0));
      send_item(make_beat(CMD_WRITE, 16'h0001, 8'hFF, '0));
      send_item(make_beat(CMD_PLAY, 16'hFFFF, '0, 17'd3));
      // zero length play must leave the slots alone
      send_item(make_beat(CMD_PLAY, 16'hAAAA, 8'h55, '0));
      repeat (3) send_item(make_beat(CMD_TICK, '0, '0, '0));
      send_item(make_beat(CMD_UNUSED, 16'hFFFF, 8'hFF, LEN_W'(65536)));
      // all four slots on the largest sample, then on the smallest
      repeat (4) send_item(make_beat(CMD_PLAY, 16'h0000, '0, 17'd1));
      send_item(make_beat(CMD_TICK, 16'hFFFF, 8'hFF, LEN_W'(65536)));
      repeat (4) send_item(make_beat(CMD_PLAY, 16'hFFFF, '0, 17'd1));
      send_item(make_beat(CMD_TICK, '0, '0, '0));
      // longest clip, left running into the random part
      send_item(make_beat(CMD_PLAY, 16'h4000, '0, LEN_W'(65536)));
      send_item(make_beat(CMD_TICK, '0, '0, '0));
   endtask

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      logic [VOL_W-1:0] vol;
      mix = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();

      // gain phases: extremes first, random settings later; no idling in phase 2 and at the end
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: vol = '0;
            1: vol = 9'd511;
            2: vol = 9'd1;
            3: vol = 9'd256;
            4: vol = 9'd255;
            default: vol = VOL_W'($urandom_range(0, 511));
         endcase
         set_out_gain(vol);
         idle_on = (ph != 2) && (ph != 7);
         repeat (PHASE_BEATS) send_item(random_beat());
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (mix.expected_mix.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mix.errors == 0 && mix.expected_mix.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
